@@ design/pee_pkg.sv @@
// Shared types and constants for the postfix expression evaluator.
// Used by the controller, the datapath and the top level.
package pee_pkg;

  localparam int DEFAULT_STACK_DEPTH = 8;

  localparam logic [7:0] TOK_PLUS  = 8'h2B;
  localparam logic [7:0] TOK_MINUS = 8'h2D;
  localparam logic [7:0] TOK_MUL   = 8'h2A;
  localparam logic [7:0] TOK_DIV   = 8'h2F;
  localparam logic [7:0] TOK_ZERO  = 8'h30;
  localparam logic [7:0] TOK_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNDER    = 3'd1,
    ST_OVER     = 3'd2,
    ST_DIVZERO  = 3'd3,
    ST_BADCHAR  = 3'd4,
    ST_LEFTOVER = 3'd5
  } status_code_t;

  typedef struct packed {
    logic         push;
    logic         load_op;
    logic         exec;
    logic         div_start;
    logic         div_apply;
    logic         err_wr;
    status_code_t err_code;
    logic         finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic err_set;
    logic is_digit;
    logic is_op;
    logic is_div;
    logic full;
    logic lt2;
    logic tos_zero;
    logic div_done;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ design/pee_div.sv @@
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// Uses pee_pkg only by convention; no package items needed beyond the header import.
module pee_div
  import pee_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  localparam int W  = 32;
  localparam int SW = $clog2(W);

  logic          busy;
  logic [SW-1:0] step;
  logic [W-1:0]  q;
  logic [W-1:0]  rem;
  logic [W-1:0]  dm;
  logic          neg;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  assign shifted  = {rem, q[W-1]};
  assign diff     = shifted - {1'b0, dm};
  assign quotient = neg ? (W'(0) - q) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + SW'(1);
        if (step == SW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend[W-1] ? (W'(0) - dividend) : dividend;
      dm  <= divisor[W-1] ? (W'(0) - divisor) : divisor;
      rem <= '0;
      neg <= dividend[W-1] ^ divisor[W-1];
    end else if (busy) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        q   <= {q[W-2:0], 1'b1};
      end else begin
        rem <= shifted[W-1:0];
        q   <= {q[W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ design/pee_ctrl.sv @@
// Controller state machine: decides per token what the datapath does.
// Depends on pee_pkg for command/status structs and status codes.
module pee_ctrl
  import pee_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      last_token,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   last_q;
  logic   accept;
  state_t after_item;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign after_item = last_q ? S_FIN : S_IDLE;

  always_comb begin
    cmd        = '0;
    cmd.err_code = ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = last_token ? S_FIN : S_IDLE;
          if (stat.err_set) begin
            // expression already failed; drop token
          end else if (stat.is_digit) begin
            if (stat.full) begin
              cmd.err_wr   = 1'b1;
              cmd.err_code = ST_OVER;
            end else begin
              cmd.push = 1'b1;
            end
          end else if (!stat.is_op) begin
            cmd.err_wr   = 1'b1;
            cmd.err_code = ST_BADCHAR;
          end else if (stat.lt2) begin
            cmd.err_wr   = 1'b1;
            cmd.err_code = ST_UNDER;
          end else if (stat.is_div) begin
            if (stat.tos_zero) begin
              cmd.err_wr   = 1'b1;
              cmd.err_code = ST_DIVZERO;
            end else begin
              cmd.load_op   = 1'b1;
              cmd.div_start = 1'b1;
              state_next    = S_DIV;
            end
          end else begin
            cmd.load_op = 1'b1;
            state_next  = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = after_item;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_apply = 1'b1;
          state_next    = after_item;
        end
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        last_q <= last_token;
      end
    end
  end

endmodule

@@ design/pee_dp.sv @@
// Datapath: top two stack entries in registers, deeper entries in a memory,
// ALU, divider, error and output registers. Depends on pee_pkg and pee_div.
module pee_dp
  import pee_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         token,
  input  ctrl_cmd_t          cmd,
  output dp_stat_t           stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] value,
  output logic [2:0]         status
);

  localparam int CW        = $clog2(STACK_DEPTH + 1);
  localparam int MEM_DEPTH = (STACK_DEPTH > 2) ? (STACK_DEPTH - 2) : 1;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  logic [CW-1:0] count;
  status_code_t  err;
  logic [31:0]   tos;
  logic [31:0]   nos;
  logic [31:0]   mem [MEM_DEPTH];
  logic [31:0]   rd_data;
  op_t           op_q;
  op_t           op_dec;
  logic [31:0]   alu_res;
  logic [31:0]   digit_val;
  logic [CW-1:0] count_m2;
  logic [CW-1:0] count_m3;
  logic          div_done;
  logic [31:0]   div_q;

  assign count_m2  = count - CW'(2);
  assign count_m3  = count - CW'(3);
  assign digit_val = {24'd0, 8'(token - TOK_ZERO)};

  always_comb begin
    case (token)
      TOK_PLUS:  op_dec = OP_ADD;
      TOK_MINUS: op_dec = OP_SUB;
      TOK_MUL:   op_dec = OP_MUL;
      default:   op_dec = OP_DIV;
    endcase
  end

  always_comb begin
    case (op_q)
      OP_ADD:  alu_res = nos + tos;
      OP_SUB:  alu_res = nos - tos;
      OP_MUL:  alu_res = nos * tos;
      default: alu_res = nos + tos;
    endcase
  end

  assign stat.err_set  = (err != ST_OK);
  assign stat.is_digit = (token >= TOK_ZERO) && (token <= TOK_NINE);
  assign stat.is_op    = (token == TOK_PLUS) || (token == TOK_MINUS) ||
                         (token == TOK_MUL) || (token == TOK_DIV);
  assign stat.is_div   = (token == TOK_DIV);
  assign stat.full     = (count >= CW'(STACK_DEPTH));
  assign stat.lt2      = (count < CW'(2));
  assign stat.tos_zero = (tos == 32'd0);
  assign stat.div_done = div_done;
  assign stat.out_busy = out_valid && !out_ready;

  pee_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (nos),
    .divisor  (tos),
    .done     (div_done),
    .quotient (div_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.push) begin
        count <= count + CW'(1);
      end
      if (cmd.exec || cmd.div_apply) begin
        count <= count - CW'(1);
      end
      if (cmd.err_wr) begin
        err <= cmd.err_code;
      end
      if (cmd.finish) begin
        count <= '0;
        err   <= ST_OK;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      tos <= digit_val;
      nos <= tos;
    end
    if (cmd.load_op) begin
      op_q <= op_dec;
    end
    if (cmd.exec) begin
      tos <= alu_res;
      nos <= rd_data;
    end
    if (cmd.div_apply) begin
      tos <= div_q;
      nos <= rd_data;
    end
    if (cmd.finish) begin
      if (err != ST_OK) begin
        value  <= '0;
        status <= err;
      end else if (count == CW'(1)) begin
        value  <= $signed(tos);
        status <= ST_OK;
      end else begin
        value  <= '0;
        status <= ST_LEFTOVER;
      end
    end
  end

  // deeper stack entries
  always_ff @(posedge clk) begin
    if (cmd.push && (count >= CW'(2))) begin
      mem[count_m2[AW-1:0]] <= nos;
    end
    if (cmd.load_op && (count >= CW'(3))) begin
      rd_data <= mem[count_m3[AW-1:0]];
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (count < CW'(STACK_DEPTH)))
    else $error("push onto full stack");

  a_pop_two: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec || cmd.div_apply) |-> (count >= CW'(2)))
    else $error("operator applied with fewer than two values");

  a_finish_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (count == '0) && (err == ST_OK) && out_valid)
    else $error("expression end did not clear stack");

endmodule

@@ design/postfix_expression_evaluator_core.sv @@
// Postfix evaluator: digits and errors are handled as the token is accepted;
// + - * pass an execute state, / the 32-step bit-serial divider. A finish
// state after the last character loads the result register, held until taken;
// input is taken only in the idle state, not during an operator or a finish.
// Reset (rst, synchronous): stack empty, no error, no result pending; the
// stack memory is not cleared and needs no clearing pass.
module postfix_expression_evaluator_core
  import pee_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         token,
  input  logic               last_token,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value,
  output logic [2:0]         status
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  pee_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .last_token (last_token),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pee_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .token     (token),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .value     (value),
    .status    (status)
  );

endmodule
